// ===== rtl/bmc_pkg.sv =====
// Shared constants for the binary mask centroid block.
`timescale 1ns / 1ps
package bmc_pkg;

  // Largest frame dimension the sums and counters are sized for.
  localparam int MAX_DIM_DEFAULT = 4096;

  // Field and register widths.
  localparam int MASK_W    = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 12;

  // Only a byte of exactly this value marks a set pixel.
  localparam logic [MASK_W-1:0] SET_VALUE = 8'hFF;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Register reset values.
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // Entries in the queue of finished frame totals.
  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/bmc_front.sv =====
// Front end: configuration registers, pixel coordinates and per-frame accumulation.
`timescale 1ns / 1ps
module bmc_front #(
  parameter int MAX_DIM = bmc_pkg::MAX_DIM_DEFAULT,
  parameter int CW      = $clog2(MAX_DIM),
  parameter int SUMW    = 3 * CW,
  parameter int CNTW    = 2 * CW + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_push,
  input  logic [bmc_pkg::MASK_W-1:0]    in_mask_value,
  output logic                          in_full,
  output logic                          q_push,
  output logic [2*SUMW+CNTW-1:0]        q_data,
  input  logic                          q_full
);
  import bmc_pkg::*;

  // Comparison width: wide enough for both the raw register and MAX_DIM itself.
  localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam logic [EW-1:0] DIM_LIMIT = EW'(MAX_DIM);

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic [CW-1:0]    row_r, row_nxt;
  logic [SUMW-1:0]  sum_x_r, sum_x_nxt;
  logic [SUMW-1:0]  sum_y_r, sum_y_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic [SUMW-1:0]  acc_x, acc_y;
  logic [CNTW-1:0]  acc_cnt;
  logic [EW-1:0]    eff_w, eff_h;
  logic             accept, pix_set, line_done, frame_end;

  function automatic logic [EW-1:0] clamp_dim(input logic [CFG_W-1:0] raw);
    logic [EW-1:0] wide;
    wide = EW'(raw);
    if (wide == '0) begin
      return EW'(1);
    end else if (wide > DIM_LIMIT) begin
      return DIM_LIMIT;
    end
    return wide;
  endfunction

  assign eff_w = clamp_dim(width_r);
  assign eff_h = clamp_dim(height_r);

  // A pixel is held off while the queue is full, so a frame end can always be pushed.
  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign pix_set = (in_mask_value == SET_VALUE);

  assign acc_x   = pix_set ? sum_x_r + SUMW'(col_r) : sum_x_r;
  assign acc_y   = pix_set ? sum_y_r + SUMW'(row_r) : sum_y_r;
  assign acc_cnt = pix_set ? cnt_r + CNTW'(1) : cnt_r;

  assign line_done = (EW'(col_r) + EW'(1)) >= eff_w;
  assign frame_end = line_done && ((EW'(row_r) + EW'(1)) >= eff_h);

  assign q_push = accept && frame_end;
  assign q_data = {acc_x, acc_y, acc_cnt};

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      if (frame_end) begin
        col_nxt   = '0;
        row_nxt   = '0;
        sum_x_nxt = '0;
        sum_y_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        sum_x_nxt = acc_x;
        sum_y_nxt = acc_y;
        cnt_nxt   = acc_cnt;
        if (line_done) begin
          col_nxt = '0;
          row_nxt = row_r + CW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RESET;
      height_r <= FRAME_HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_r  <= cfg_data;
          CFG_FRAME_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/bmc_fifo.sv =====
// Short queue of frame totals between the front end and the divide stage.
`timescale 1ns / 1ps
module bmc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bmc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import bmc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;
  logic             do_push, do_pop;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
    return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
  endfunction

  assign full     = (count_r == NW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + NW'(1);
        2'b01:   count_r <= count_r - NW'(1);
        default: ;
      endcase
    end
  end

  // The front end holds pixels off while the queue is full, so no frame is dropped.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("frame totals pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(DEPTH))
    else $error("queue fill count beyond its depth");

endmodule

// ===== rtl/bmc_div.sv =====
// Restoring divider, one quotient bit per cycle, for a quotient known to fit in QW bits.
`timescale 1ns / 1ps
module bmc_div #(
  parameter int QW = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [3*QW-1:0]   dividend,
  input  logic [2*QW:0]     divisor,
  output logic              done,
  output logic [QW-1:0]     quotient
);
  import bmc_pkg::*;

  localparam int SUMW = 3 * QW;
  localparam int CNTW = 2 * QW + 1;
  localparam int SW   = $clog2(QW + 1);

  logic [CNTW-1:0] rem_r;
  logic [CNTW-1:0] dsr_r;
  logic [QW-1:0]   q_r;
  logic [SW-1:0]   step_r;
  logic            busy_r, done_r;
  logic [CNTW:0]   trial;
  logic            fits;

  // The quotient fits in QW bits, so the upper part of the dividend is already
  // below the divisor and only QW steps are needed.
  assign trial    = {rem_r, q_r[QW-1]};
  assign fits     = trial >= {1'b0, dsr_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CNTW'(dividend[SUMW-1:QW]);
      q_r   <= dividend[QW-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? CNTW'(trial - {1'b0, dsr_r}) : CNTW'(trial);
      q_r   <= QW'({q_r, fits});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(QW);
      end else if (busy_r) begin
        step_r <= step_r - SW'(1);
        if (step_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/bmc_back.sv =====
// Back end: takes frame totals from the queue, divides them and holds the result.
`timescale 1ns / 1ps
module bmc_back #(
  parameter int CW   = 12,
  parameter int SUMW = 3 * CW,
  parameter int CNTW = 2 * CW + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  logic [2*SUMW+CNTW-1:0]      q_data,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [bmc_pkg::OUT_W-1:0]   out_centroid_x,
  output logic [bmc_pkg::OUT_W-1:0]   out_centroid_y,
  output logic                        out_found
);
  import bmc_pkg::*;

  typedef enum logic {IDLE, DIVIDE} state_t;

  state_t          state_r;
  logic            out_valid_r;
  logic            found_r;
  logic [OUT_W-1:0] cx_r, cy_r;
  logic            pend_found_r;
  logic [SUMW-1:0] head_x, head_y;
  logic [CNTW-1:0] head_cnt;
  logic [CW-1:0]   qx, qy;
  logic            done_x, done_y;

  assign {head_x, head_y, head_cnt} = q_data;

  // Start a division only when the result register is free to take its answer.
  assign q_pop = (state_r == IDLE) && !q_empty && !out_valid_r;

  bmc_div #(.QW(CW)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (q_pop),
    .dividend (head_x),
    .divisor  (head_cnt),
    .done     (done_x),
    .quotient (qx)
  );

  bmc_div #(.QW(CW)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (q_pop),
    .dividend (head_y),
    .divisor  (head_cnt),
    .done     (done_y),
    .quotient (qy)
  );

  assign out_empty      = !out_valid_r;
  assign out_centroid_x = cx_r;
  assign out_centroid_y = cy_r;
  assign out_found      = found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      out_valid_r  <= 1'b0;
      pend_found_r <= 1'b0;
      found_r      <= 1'b0;
      cx_r         <= '0;
      cy_r         <= '0;
    end else begin
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (q_pop) begin
            pend_found_r <= (head_cnt != '0);
            state_r      <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (done_x) begin
            // An empty frame divides by zero; its quotient is discarded.
            cx_r        <= pend_found_r ? OUT_W'(qx) : '0;
            cy_r        <= pend_found_r ? OUT_W'(qy) : '0;
            found_r     <= pend_found_r;
            out_valid_r <= 1'b1;
            state_r     <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  a_dividers_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    done_x == done_y)
    else $error("column and row dividers out of step");

  a_done_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    done_x |-> (state_r == DIVIDE))
    else $error("divider finished with no division outstanding");

  a_result_free_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DIVIDE) |-> !out_valid_r)
    else $error("division running while a result is still held");

endmodule

// ===== rtl/binary_mask_centroid.sv =====
// Top level of the binary mask centroid block.
// Mask bytes arrive in raster order, one per clock while in_full is low; a byte
// of 255 marks a set pixel and the block keeps its own column and row count from
// the frame_width and frame_height registers (0 acts as 1, values above MAX_DIM
// act as MAX_DIM). The last pixel of a frame hands the column sum, row sum and
// set-pixel count to a two-entry queue and the accumulators clear at once, so the
// next frame streams on without a gap. Two dividers then work out the mean column
// and row one quotient bit per cycle; the result is held in a result register on
// the out_ ports, which must be popped before the next division starts, and a new
// division waits until the previous one is done. A frame without set pixels reports
// 0,0 with out_found low.
`timescale 1ns / 1ps
module binary_mask_centroid #(
  parameter int MAX_DIM = bmc_pkg::MAX_DIM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_push,
  input  logic [bmc_pkg::MASK_W-1:0]    in_mask_value,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [bmc_pkg::OUT_W-1:0]     out_centroid_x,
  output logic [bmc_pkg::OUT_W-1:0]     out_centroid_y,
  output logic                          out_found
);
  import bmc_pkg::*;

  localparam int CW   = $clog2(MAX_DIM);
  localparam int SUMW = 3 * CW;
  localparam int CNTW = 2 * CW + 1;
  localparam int QDW  = 2 * SUMW + CNTW;

  logic           q_push, q_full, q_pop, q_empty;
  logic [QDW-1:0] q_wdata, q_rdata;

  bmc_front #(
    .MAX_DIM (MAX_DIM),
    .CW      (CW),
    .SUMW    (SUMW),
    .CNTW    (CNTW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_mask_value (in_mask_value),
    .in_full       (in_full),
    .q_push        (q_push),
    .q_data        (q_wdata),
    .q_full        (q_full)
  );

  bmc_fifo #(
    .WIDTH (QDW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  bmc_back #(
    .CW   (CW),
    .SUMW (SUMW),
    .CNTW (CNTW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_centroid_x (out_centroid_x),
    .out_centroid_y (out_centroid_y),
    .out_found      (out_found)
  );

endmodule
